// File: src/bba_pkg.sv
// ----------------------------------------------------------------------------
// Bitmap block allocator package
// Sizes, codes, interface types and bitmap mask helpers shared by the
// allocator modules.
// ----------------------------------------------------------------------------
package bba_pkg;

  // Device and bitmap geometry.
  localparam int MAX_BLOCKS     = 4096;
  localparam int WORD_BITS      = 64;
  localparam int BLOCK_BYTES    = 512;
  localparam int NUM_WORDS      = (MAX_BLOCKS + WORD_BITS - 1) / WORD_BITS;
  localparam int ADDR_W         = $clog2(NUM_WORDS);
  localparam int BIT_W          = $clog2(WORD_BITS);
  localparam int IDX_W          = 12;
  localparam int TOTAL_W        = 13;
  localparam int TOTAL_RESET    = 4096;
  localparam int SYS_BLOCKS     = 2;
  localparam int BITS_PER_BLOCK = 8 * BLOCK_BYTES;

  // Command codes carried on the input channel.
  typedef enum logic [1:0] {
    CMD_FORMAT = 2'd0,
    CMD_FIND   = 2'd1,
    CMD_FREE   = 2'd2
  } cmd_e;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_NONE  = 2'd1,
    ST_RANGE = 2'd2
  } status_e;

  // One access to the bitmap memory.
  typedef struct packed {
    logic                 rd_en;
    logic [ADDR_W-1:0]    rd_addr;
    logic                 wr_en;
    logic [ADDR_W-1:0]    wr_addr;
    logic [WORD_BITS-1:0] wr_data;
  } mem_req_t;

  // One finished result handed from the controller to the output stage.
  typedef struct packed {
    status_e          status;
    logic [IDX_W-1:0] free_index;
    logic             batch_done;
  } result_t;

  // Bits of bitmap word 'word' whose block number lies below 'limit'.
  function automatic logic [WORD_BITS-1:0] word_mask(logic [TOTAL_W-1:0] limit,
                                                     logic [ADDR_W-1:0]  word);
    logic [TOTAL_W-1:0]   base;
    logic [TOTAL_W-1:0]   span;
    logic [WORD_BITS-1:0] m;
    base = TOTAL_W'(word) << BIT_W;
    span = limit - base;
    if (limit <= base) begin
      m = '0;
    end else if (span >= TOTAL_W'(WORD_BITS)) begin
      m = '1;
    end else begin
      m = (WORD_BITS'(1) << span[BIT_W-1:0]) - WORD_BITS'(1);
    end
    return m;
  endfunction

  // Number of blocks that a format marks used, clamped to the capacity.
  function automatic logic [TOTAL_W-1:0] reserved_count(logic [TOTAL_W-1:0] total);
    logic [31:0] r;
    r = 32'(SYS_BLOCKS) + (32'(total) + 32'(BITS_PER_BLOCK - 1)) / 32'(BITS_PER_BLOCK);
    if (r > 32'(MAX_BLOCKS)) begin
      r = 32'(MAX_BLOCKS);
    end
    return TOTAL_W'(r);
  endfunction

endpackage

// File: src/bba_bitmap_ram.sv
// ----------------------------------------------------------------------------
// Bitmap word memory
// Single-port-per-direction memory of bitmap words with a registered read and
// one valid flag per word, so that a word never written reads as all free.
// ----------------------------------------------------------------------------
module bba_bitmap_ram import bba_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  mem_req_t             req_i,
  output logic [WORD_BITS-1:0] rd_data_o
);

  logic [WORD_BITS-1:0] mem_q [NUM_WORDS];
  logic [WORD_BITS-1:0] rdata_q;
  logic [NUM_WORDS-1:0] valid_q;
  logic                 rvalid_q;

  // Word storage: write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem_q[req_i.wr_addr] <= req_i.wr_data;
    end
    if (req_i.rd_en) begin
      rdata_q <= mem_q[req_i.rd_addr];
    end
  end

  // Valid flags are cleared by reset, which makes the whole bitmap free.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      rvalid_q <= 1'b0;
    end else begin
      if (req_i.wr_en) begin
        valid_q[req_i.wr_addr] <= 1'b1;
      end
      if (req_i.rd_en) begin
        rvalid_q <= valid_q[req_i.rd_addr];
      end
    end
  end

  // A word that was never written reads as zero.
  assign rd_data_o = rvalid_q ? rdata_q : '0;

endmodule

// File: src/bba_ctrl.sv
// ----------------------------------------------------------------------------
// Bitmap allocator controller
// Sequencer that runs format sweeps, pipelined find scans and free
// read-modify-write operations against the bitmap memory.
// ----------------------------------------------------------------------------
module bba_ctrl import bba_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [1:0]           command_i,
  input  logic [IDX_W-1:0]     block_index_i,
  input  logic                 batch_end_i,
  input  logic [TOTAL_W-1:0]   eff_total_i,
  output mem_req_t             mem_req_o,
  input  logic [WORD_BITS-1:0] mem_rd_data_i,
  output logic                 res_valid_o,
  output result_t              res_o,
  input  logic                 res_ready_i
);

  typedef enum logic [5:0] {
    S_IDLE    = 6'b000001,
    S_FMT     = 6'b000010,
    S_FIND    = 6'b000100,
    S_FREE_RD = 6'b001000,
    S_FREE_WR = 6'b010000,
    S_DONE    = 6'b100000
  } state_e;

  localparam logic [ADDR_W-1:0] LAST_WORD = ADDR_W'(NUM_WORDS - 1);

  // Position of the lowest set bit of a word.
  function automatic logic [BIT_W-1:0] lowest_set(logic [WORD_BITS-1:0] v);
    logic [BIT_W-1:0] r;
    r = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (v[i]) begin
        r = BIT_W'(i);
      end
    end
    return r;
  endfunction

  state_e             state_q, state_d;
  logic               more_q, more_d;
  logic               chk_q, chk_d;
  logic [ADDR_W-1:0]  ptr_q, ptr_d;
  logic [ADDR_W-1:0]  chk_addr_q, chk_addr_d;
  logic [IDX_W-1:0]   idx_q, idx_d;
  result_t            res_q, res_d;

  logic [WORD_BITS-1:0] free_bits;
  logic [ADDR_W-1:0]    idx_word;
  logic [TOTAL_W-1:0]   reserved;

  assign idx_word  = idx_q[BIT_W +: ADDR_W];
  assign reserved  = reserved_count(eff_total_i);
  assign free_bits = ~mem_rd_data_i & word_mask(eff_total_i, chk_addr_q);

  // Next-state and memory access logic.
  always_comb begin
    state_d    = state_q;
    more_d     = more_q;
    chk_d      = 1'b0;
    ptr_d      = ptr_q;
    chk_addr_d = chk_addr_q;
    idx_d      = idx_q;
    res_d      = res_q;
    mem_req_o  = '0;

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          idx_d            = block_index_i;
          res_d.status     = ST_OK;
          res_d.free_index = '0;
          res_d.batch_done = batch_end_i;
          ptr_d            = '0;
          case (cmd_e'(command_i))
            CMD_FORMAT: state_d = S_FMT;
            CMD_FIND: begin
              more_d  = 1'b1;
              state_d = S_FIND;
            end
            CMD_FREE: begin
              if ({1'b0, block_index_i} >= eff_total_i) begin
                res_d.status = ST_RANGE;
                state_d      = S_DONE;
              end else begin
                state_d = S_FREE_RD;
              end
            end
            default: state_d = S_DONE;
          endcase
        end
      end

      // Write one word of the format pattern per cycle.
      S_FMT: begin
        mem_req_o.wr_en   = 1'b1;
        mem_req_o.wr_addr = ptr_q;
        mem_req_o.wr_data = word_mask(reserved, ptr_q);
        ptr_d             = ptr_q + ADDR_W'(1);
        if (ptr_q == LAST_WORD) begin
          state_d = S_DONE;
        end
      end

      // Issue one read per cycle and check the word read in the cycle before.
      S_FIND: begin
        mem_req_o.rd_en   = more_q;
        mem_req_o.rd_addr = ptr_q;
        chk_d             = more_q;
        chk_addr_d        = ptr_q;
        if (more_q) begin
          ptr_d = ptr_q + ADDR_W'(1);
          if (ptr_q == LAST_WORD) begin
            more_d = 1'b0;
          end
        end
        if (chk_q) begin
          if (|free_bits) begin
            res_d.status     = ST_OK;
            res_d.free_index = IDX_W'({chk_addr_q, lowest_set(free_bits)});
            more_d           = 1'b0;
            state_d          = S_DONE;
          end else if (chk_addr_q == LAST_WORD) begin
            res_d.status = ST_NONE;
            more_d       = 1'b0;
            state_d      = S_DONE;
          end
        end
      end

      // Free: read the word, then write it back with the bit cleared.
      S_FREE_RD: begin
        mem_req_o.rd_en   = 1'b1;
        mem_req_o.rd_addr = idx_word;
        state_d           = S_FREE_WR;
      end

      S_FREE_WR: begin
        mem_req_o.wr_en   = 1'b1;
        mem_req_o.wr_addr = idx_word;
        mem_req_o.wr_data = mem_rd_data_i & ~(WORD_BITS'(1) << idx_q[BIT_W-1:0]);
        state_d           = S_DONE;
      end

      // Hold the result until the output stage takes it.
      S_DONE: begin
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      more_q  <= 1'b0;
      chk_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      more_q  <= more_d;
      chk_q   <= chk_d;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    ptr_q      <= ptr_d;
    chk_addr_q <= chk_addr_d;
    idx_q      <= idx_d;
    res_q      <= res_d;
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign res_valid_o = (state_q == S_DONE);
  assign res_o       = res_q;

endmodule

// File: src/bitmap_block_allocator_top.sv
// ----------------------------------------------------------------------------
// Bitmap block allocator
// Keeps a used/free bitmap with one bit per device block and serves format,
// find-first-free and free commands.
// ----------------------------------------------------------------------------
//  Channel  Direction  Handshake            Payload
//  in       to block   in_valid_i/in_stall_o   command, block_index, batch_end
//  out      from block out_valid_o/out_stall_i status, free_index, batch_done
//  cfg      to block   cfg_we_i               total_blocks (cfg_wdata_i)
//
// Format writes every bitmap word once, one word per cycle. Find reads one
// word per cycle and checks it in the cycle after, until it finds a free block
// below the total or has checked the last word. Free takes one read and one
// write. The input stall drops in the same cycle as the result shows at the
// output. Reset clears the bitmap at once.
// A new command is taken while a result still waits on a stalled output.
// ----------------------------------------------------------------------------
module bitmap_block_allocator_top import bba_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         command_i,
  input  logic [IDX_W-1:0]   block_index_i,
  input  logic               batch_end_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [1:0]         status_o,
  output logic [IDX_W-1:0]   free_index_o,
  output logic               batch_done_o,
  input  logic               cfg_we_i,
  input  logic [TOTAL_W-1:0] cfg_wdata_i
);

  logic [TOTAL_W-1:0]   total_q;
  logic [TOTAL_W-1:0]   eff_total;
  mem_req_t             mem_req;
  logic [WORD_BITS-1:0] mem_rd_data;
  logic                 res_valid;
  result_t              res;
  logic                 out_ready;
  logic                 out_valid_q;
  result_t              out_q;

  // Total block count register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q <= TOTAL_W'(TOTAL_RESET);
    end else if (cfg_we_i) begin
      total_q <= cfg_wdata_i;
    end
  end

  // A total above the capacity counts as the capacity.
  assign eff_total = (total_q > TOTAL_W'(MAX_BLOCKS)) ? TOTAL_W'(MAX_BLOCKS) : total_q;

  bba_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .command_i     (command_i),
    .block_index_i (block_index_i),
    .batch_end_i   (batch_end_i),
    .eff_total_i   (eff_total),
    .mem_req_o     (mem_req),
    .mem_rd_data_i (mem_rd_data),
    .res_valid_o   (res_valid),
    .res_o         (res),
    .res_ready_i   (out_ready)
  );

  bba_bitmap_ram u_ram (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (mem_req),
    .rd_data_o (mem_rd_data)
  );

  // Output register: free when empty or when its transfer completes.
  assign out_ready = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_ready && res_valid) begin
      out_q <= res;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign status_o     = out_q.status;
  assign free_index_o = out_q.free_index;
  assign batch_done_o = out_q.batch_done;

endmodule

// File: src/bba_checker.sv
// ----------------------------------------------------------------------------
// Bitmap allocator port checker
// Concurrent checks on the top-level ports, attached by a bind statement.
// ----------------------------------------------------------------------------
module bba_checker import bba_pkg::*; (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_stall_o,
  input logic [1:0]         command_i,
  input logic [IDX_W-1:0]   block_index_i,
  input logic               batch_end_i,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input logic [1:0]         status_o,
  input logic [IDX_W-1:0]   free_index_o,
  input logic               batch_done_o,
  input logic               cfg_we_i,
  input logic [TOTAL_W-1:0] cfg_wdata_i
);

  // A stalled result keeps its valid and its payload.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=>
      out_valid_o && $stable(status_o) && $stable(free_index_o) && $stable(batch_done_o))
    else $error("stalled result changed");

  // A stalled command keeps its valid and its payload.
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_stall_o |=>
      in_valid_i && $stable(command_i) && $stable(block_index_i) && $stable(batch_end_i))
    else $error("stalled command changed");

  // Every command keeps the block busy in the cycle after its transfer.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input not stalled after a transfer");

  // Only a successful find reports a nonzero block index.
  a_index_on_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != ST_OK) |-> free_index_o == '0)
    else $error("nonzero index with a failing status");

  // The block total is written only while the block is idle.
  a_cfg_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i |-> !in_stall_o && !out_valid_o && !$isunknown(cfg_wdata_i))
    else $error("total written while a command is in flight");

endmodule

bind bitmap_block_allocator_top bba_checker u_bba_checker (.*);

// File: test/bitmap_block_allocator_checker.sv
// ----------------------------------------------------------------------------
// Bitmap block allocator checker
// Watches the command, result and configuration ports of the allocator. It
// keeps its own copy of the used/free bitmap and the block total, works out
// the result of every accepted command, and compares each result transfer
// with the oldest prediction still waiting.
// ----------------------------------------------------------------------------
module bitmap_block_allocator_checker import bba_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_stall_i,
  input  logic [1:0]         command_i,
  input  logic [IDX_W-1:0]   block_index_i,
  input  logic               batch_end_i,
  input  logic               out_valid_i,
  input  logic               out_stall_i,
  input  logic [1:0]         status_i,
  input  logic [IDX_W-1:0]   free_index_i,
  input  logic               batch_done_i,
  input  logic               cfg_we_i,
  input  logic [TOTAL_W-1:0] cfg_wdata_i,
  output int unsigned        fail_count_o,
  output int unsigned        outstanding_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_REPORTS = 10;

  // Shadow copy of the bitmap (bit set = used) and of the block total.
  logic [WORD_BITS-1:0] used_map [NUM_WORDS];
  logic [TOTAL_W-1:0]   total_cfg;

  // Results predicted for accepted commands, oldest first.
  result_t predicted_results [$];
  result_t observed;
  result_t wanted;
  result_t fresh;
  int      word_nr;
  int      result_nr;

  // Apply one command to the shadow bitmap and return the result it gives.
  task automatic apply_command(input logic [1:0] cmd, input logic [IDX_W-1:0] idx,
                               input logic be, output result_t res);
    int eff;
    int reserved;
    int b;
    eff = (int'(total_cfg) > MAX_BLOCKS) ? MAX_BLOCKS : int'(total_cfg);
    res.status     = ST_OK;
    res.free_index = '0;
    res.batch_done = be;
    case (cmd)
      CMD_FORMAT: begin
        // The system blocks plus the bitmap blocks themselves are marked used.
        reserved = SYS_BLOCKS + (eff + BITS_PER_BLOCK - 1) / BITS_PER_BLOCK;
        if (reserved > MAX_BLOCKS) begin
          reserved = MAX_BLOCKS;
        end
        for (b = 0; b < NUM_WORDS; b++) begin
          used_map[b] = '0;
        end
        for (b = 0; b < reserved; b++) begin
          used_map[b / WORD_BITS][b % WORD_BITS] = 1'b1;
        end
      end
      CMD_FIND: begin
        // Lowest clear bit below the total; the bitmap is left as it is.
        res.status = ST_NONE;
        for (b = 0; b < eff && res.status == ST_NONE; b++) begin
          if (!used_map[b / WORD_BITS][b % WORD_BITS]) begin
            res.status     = ST_OK;
            res.free_index = IDX_W'(b);
          end
        end
      end
      CMD_FREE: begin
        if (int'(idx) >= eff) begin
          res.status = ST_RANGE;
        end else begin
          used_map[int'(idx) / WORD_BITS][int'(idx) % WORD_BITS] = 1'b0;
        end
      end
      default: begin
        // The unused command code changes nothing.
      end
    endcase
  endtask

  // Track transfers on every channel at the rising edge.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (word_nr = 0; word_nr < NUM_WORDS; word_nr++) begin
        used_map[word_nr] = '0;
      end
      total_cfg = TOTAL_W'(TOTAL_RESET);
      predicted_results.delete();
      fail_count_o = 0;
      result_nr    = 0;
    end else begin
      // A result transfer is checked against the oldest prediction.
      if (out_valid_i && !out_stall_i) begin
        observed = '{status: status_e'(status_i), free_index: free_index_i,
                     batch_done: batch_done_i};
        if (predicted_results.size() == 0) begin
          fail_count_o++;
          if (fail_count_o <= MAX_REPORTS) begin
            $display("Result %0d arrived with none expected: %s %0d index %0d done %0d",
                     result_nr, "status", status_i, free_index_i, batch_done_i);
          end
        end else begin
          wanted = predicted_results.pop_front();
          if (observed !== wanted) begin
            fail_count_o++;
            if (fail_count_o <= MAX_REPORTS) begin
              $display("Result %0d mismatch: expected status %0d index %0d done %0d,",
                       result_nr, wanted.status, wanted.free_index, wanted.batch_done);
              $display("  got status %0d index %0d done %0d",
                       status_i, free_index_i, batch_done_i);
            end
          end
        end
        result_nr++;
      end
      // A command transfer adds one prediction.
      if (in_valid_i && !in_stall_i) begin
        apply_command(command_i, block_index_i, batch_end_i, fresh);
        predicted_results.push_back(fresh);
      end
      if (cfg_we_i) begin
        total_cfg = cfg_wdata_i;
      end
    end
    outstanding_o = predicted_results.size();
  end

endmodule

// File: test/bitmap_block_allocator_top_test.sv
// ----------------------------------------------------------------------------
// Bitmap block allocator testbench
// Drives format, find and free commands into the allocator under several
// block totals, with random idle bursts on both channels, one long output
// hold-off and a calm final phase. A separate checker predicts and compares
// every result; this module builds the stimulus and reports the verdict.
// ----------------------------------------------------------------------------
module bitmap_block_allocator_top_test;
  timeunit 1ns;
  timeprecision 1ps;
  import bba_pkg::*;

  localparam int CLK_PERIOD   = 20;
  localparam int RESET_CYCLES = 8;
  localparam int CYCLE_LIMIT  = 500000;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 80;
  localparam int RANDOM_ITEMS = 1300;
  localparam int NUM_PHASES   = 14;
  localparam int PER_PHASE    = RANDOM_ITEMS / NUM_PHASES;
  localparam int HOLD_PHASE   = 2;
  localparam int PAUSE_PHASE  = 6;

  logic               clk_i         = 1'b0;
  logic               rst_ni        = 1'b0;
  logic               in_valid_i    = 1'b0;
  logic               in_stall_o;
  logic [1:0]         command_i     = CMD_FIND;
  logic [IDX_W-1:0]   block_index_i = '0;
  logic               batch_end_i   = 1'b0;
  logic               out_valid_o;
  logic               out_stall_i   = 1'b0;
  logic [1:0]         status_o;
  logic [IDX_W-1:0]   free_index_o;
  logic               batch_done_o;
  logic               cfg_we_i      = 1'b0;
  logic [TOTAL_W-1:0] cfg_wdata_i   = '0;

  int unsigned fail_count;
  int unsigned outstanding;
  int          cycle_count   = 0;
  int          items_sent    = 0;
  int          stall_left    = 0;
  int          hold_requests = 0;
  int          holds_served  = 0;
  logic        calm          = 1'b0;

  bitmap_block_allocator_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .command_i     (command_i),
    .block_index_i (block_index_i),
    .batch_end_i   (batch_end_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .status_o      (status_o),
    .free_index_o  (free_index_o),
    .batch_done_o  (batch_done_o),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  bitmap_block_allocator_checker checker_inst (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_i    (in_stall_o),
    .command_i     (command_i),
    .block_index_i (block_index_i),
    .batch_end_i   (batch_end_i),
    .out_valid_i   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .status_i      (status_o),
    .free_index_i  (free_index_o),
    .batch_done_i  (batch_done_o),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .fail_count_o  (fail_count),
    .outstanding_o (outstanding)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // Guard against a hung run.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Result receiver: random stall bursts, plus one long hold-off on request.
  always @(negedge clk_i) begin
    if (stall_left != 0) begin
      stall_left  <= stall_left - 1;
      out_stall_i <= 1'b1;
    end else if (hold_requests != holds_served) begin
      holds_served <= holds_served + 1;
      stall_left   <= HOLD_CYCLES - 1;
      out_stall_i  <= 1'b1;
    end else if (!calm && $urandom_range(0, 5) == 0) begin
      stall_left  <= $urandom_range(0, 8);
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // Offer one command and hold it until its transfer. Called at a falling edge.
  task automatic send_cmd(input logic [1:0] cmd, input logic [IDX_W-1:0] idx,
                          input logic be);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 9)) @(negedge clk_i);
    end
    in_valid_i    <= 1'b1;
    command_i     <= cmd;
    block_index_i <= idx;
    batch_end_i   <= be;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    items_sent++;
    @(negedge clk_i);
  endtask

  // Drop valid and wait until every predicted result has come back.
  task automatic wait_results;
    in_valid_i <= 1'b0;
    while (outstanding != 0) @(negedge clk_i);
  endtask

  // Write the block total while the allocator is idle.
  task automatic set_total(input logic [TOTAL_W-1:0] value);
    wait_results();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Pick a block number to free: low blocks, the edge of the total, or anywhere.
  function automatic logic [IDX_W-1:0] pick_free_index(input int eff);
    int pick;
    int near;
    pick = $urandom_range(0, 9);
    if (pick < 3) begin
      return IDX_W'($urandom_range(0, 7));
    end else if (pick < 5) begin
      near = eff + $urandom_range(0, 3) - 2;
      if (near < 0) near = 0;
      if (near > MAX_BLOCKS - 1) near = MAX_BLOCKS - 1;
      return IDX_W'(near);
    end else if (pick < 7 && eff > 0) begin
      return IDX_W'($urandom_range(0, eff - 1));
    end
    return IDX_W'($urandom);
  endfunction

  // Mostly a list of frees closed by batch_end and followed by a find,
  // sometimes after a format; the rest is single random commands.
  task automatic send_random_sequence(input int eff);
    int n;
    int i;
    if ($urandom_range(0, 9) < 7) begin
      if ($urandom_range(0, 3) == 0) begin
        send_cmd(CMD_FORMAT, IDX_W'($urandom), 1'($urandom_range(0, 1)));
      end
      n = $urandom_range(1, 6);
      for (i = 0; i < n; i++) begin
        send_cmd(CMD_FREE, pick_free_index(eff), i == n - 1);
      end
      send_cmd(CMD_FIND, IDX_W'($urandom), 1'b0);
    end else begin
      send_cmd(2'($urandom_range(0, 3)), pick_free_index(eff),
               1'($urandom_range(0, 1)));
    end
  endtask

  // Main stimulus.
  initial begin
    logic [TOTAL_W-1:0] phase_total;
    int                 eff;
    int                 p;
    int                 i;
    int                 target;
    logic               paused;

    paused = 1'b0;
    repeat (RESET_CYCLES) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: reset bitmap with the reset total, then format and frees.
    send_cmd(CMD_FIND, '0, 1'b0);
    send_cmd(CMD_FORMAT, '0, 1'b0);
    send_cmd(CMD_FIND, '1, 1'b1);
    send_cmd(CMD_FREE, IDX_W'(1), 1'b0);
    send_cmd(CMD_FREE, '0, 1'b1);
    send_cmd(CMD_FIND, '0, 1'b0);
    send_cmd(CMD_FREE, '1, 1'b1);
    send_cmd(2'd3, '1, 1'b1);
    send_cmd(CMD_FORMAT, '1, 1'b1);

    // A total of zero: nothing to find and every free is out of range.
    set_total('0);
    send_cmd(CMD_FIND, '0, 1'b0);
    send_cmd(CMD_FREE, '0, 1'b1);
    send_cmd(CMD_FORMAT, '0, 1'b0);
    send_cmd(CMD_FIND, '0, 1'b0);
    send_cmd(CMD_FREE, '1, 1'b0);

    // A total above the capacity acts as the capacity.
    set_total('1);
    send_cmd(CMD_FIND, '0, 1'b0);
    send_cmd(CMD_FREE, '1, 1'b0);
    send_cmd(CMD_FREE, '0, 1'b1);
    send_cmd(CMD_FIND, '0, 1'b0);

    // A tiny total that the format reservation covers completely.
    set_total(TOTAL_W'(2));
    send_cmd(CMD_FORMAT, '0, 1'b0);
    send_cmd(CMD_FIND, '0, 1'b0);
    send_cmd(CMD_FREE, IDX_W'(1), 1'b1);
    send_cmd(CMD_FIND, '0, 1'b0);
    send_cmd(CMD_FREE, IDX_W'(2), 1'b1);

    // Random phases, each under its own block total.
    target = items_sent;
    for (p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0:       phase_total = TOTAL_W'(TOTAL_RESET);
        1:       phase_total = '1;
        2:       phase_total = '0;
        3:       phase_total = TOTAL_W'(1);
        4:       phase_total = TOTAL_W'(3);
        5:       phase_total = TOTAL_W'(4);
        6:       phase_total = TOTAL_W'(64);
        7:       phase_total = TOTAL_W'(65);
        8:       phase_total = TOTAL_W'(MAX_BLOCKS - 1);
        9:       phase_total = TOTAL_W'(MAX_BLOCKS + 1);
        10:      phase_total = TOTAL_W'($urandom_range(5, 4095));
        11:      phase_total = TOTAL_W'($urandom_range(0, 8191));
        12:      phase_total = TOTAL_W'($urandom_range(0, 8191));
        default: phase_total = TOTAL_W'(TOTAL_RESET);
      endcase
      eff = (int'(phase_total) > MAX_BLOCKS) ? MAX_BLOCKS : int'(phase_total);
      if (p == NUM_PHASES - 1) begin
        calm <= 1'b1;
      end
      set_total(phase_total);
      send_cmd(CMD_FORMAT, IDX_W'($urandom), 1'b0);

      // Long output hold-off while commands keep coming.
      if (p == HOLD_PHASE) begin
        hold_requests <= hold_requests + 1;
        for (i = 0; i < 12; i++) begin
          send_cmd(2'($urandom_range(0, 3)), pick_free_index(eff),
                   1'($urandom_range(0, 1)));
        end
      end

      target += PER_PHASE;
      while (items_sent < target) begin
        if (p == PAUSE_PHASE && !paused && items_sent >= target - PER_PHASE / 2) begin
          paused = 1'b1;
          wait_results();
        end
        send_random_sequence(eff);
      end
    end

    // Drain, let the block settle, then report.
    wait_results();
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (fail_count == 0 && outstanding == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// File: filelist.f
src/bba_pkg.sv
src/bba_bitmap_ram.sv
src/bba_ctrl.sv
src/bitmap_block_allocator_top.sv
src/bba_checker.sv
test/bitmap_block_allocator_checker.sv
test/bitmap_block_allocator_top_test.sv
